@@ sv/col_pkg.sv @@
// shared types, constants and helpers for the circle overlap resolver
package col_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int DIV_STEPS   = FRAC_BITS + 1;
    localparam int SQRT_STEPS  = 32;
    localparam int EPS_CALC    = ((1 << FRAC_BITS) + 5000) / 10000;
    localparam int EPS_INT     = (EPS_CALC == 0) ? 1 : EPS_CALC;
    localparam logic [32:0] EPS_RAW = 33'(EPS_INT);

    typedef struct packed {
        logic               first_is_circle;
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic [30:0]        first_radius;
        logic               second_is_circle;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic [30:0]        second_radius;
    } t_in;

    typedef struct packed {
        logic               moved;
        logic signed [31:0] new_first_x;
        logic signed [31:0] new_first_y;
        logic signed [31:0] new_second_x;
        logic signed [31:0] new_second_y;
    } t_out;

    // pair data that rides along the chain
    typedef struct packed {
        logic        hit;
        logic [31:0] x1;
        logic [31:0] y1;
        logic [31:0] x2;
        logic [31:0] y2;
        logic        neg_x;
        logic        neg_y;
        logic [31:0] sum;
        logic [31:0] adx;
        logic [31:0] ady;
    } t_side;

    typedef struct packed {
        logic [63:0] n;
        logic [63:0] r;
    } t_sqrt;

    typedef struct packed {
        logic [32:0]          dvsr;
        logic [32:0]          rem_x;
        logic [32:0]          rem_y;
        logic                 bit_x;
        logic                 bit_y;
        logic [DIV_STEPS-1:0] q_x;
        logic [DIV_STEPS-1:0] q_y;
        logic [30:0]          push;
    } t_div;

    function automatic logic [31:0] sat34(input logic signed [33:0] v);
        logic [31:0] res;
        if (v > 34'sd2147483647) begin
            res = 32'h7FFF_FFFF;
        end else if (v < -34'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

@@ sv/col_in_if.sv @@
// input channel carrying one candidate pair per beat
interface col_in_if;
    import col_pkg::*;
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/col_out_if.sv @@
// output channel carrying one resolved pair per beat
interface col_out_if;
    import col_pkg::*;
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/circle_overlap_resolver.sv @@
// accept to output beat: stages a, b and c, the root chain, stage d, the divide chain, stage e, output register; Q16.16
// throughput: one pair per cycle while the skid is empty; a 32-cell root chain and a 17-cell divide chain set depth
// the whole chain advances together; a one-entry skid behind the output register
// lets input be taken while a result waits
// reset: synchronous active-low, clears all valid bits, including those of the skid and output register
module circle_overlap_resolver (
    input  logic i_clk,
    input  logic i_rst_n,
    col_in_if.sink    i_in,
    col_out_if.source o_out
);
    import col_pkg::*;

    logic w_en;

    // stage a: differences, radius sum, box test
    logic        r_a_v;
    t_side       r_a;
    t_side       n_a;
    logic signed [32:0] w_dx;
    logic signed [32:0] w_dy;
    logic [32:0] w_adx;
    logic [32:0] w_ady;
    logic [31:0] w_sum;

    // stage b: squares
    logic        r_b_v;
    t_side       r_b;
    logic [63:0] r_b_a;
    logic [63:0] r_b_b;
    logic [63:0] r_b_m2;

    // stage c: strict overlap test, radicand
    logic        r_c_v;
    t_side       r_c;
    t_side       n_c;
    t_sqrt       r_c_sq;

    logic        w_sq_v[0:SQRT_STEPS];
    t_side       w_sq_side[0:SQRT_STEPS];
    t_sqrt       w_sq[0:SQRT_STEPS];

    // stage d: rounding, epsilon, push
    logic        r_d_v;
    t_side       r_d;
    t_div        r_d_dv;
    t_div        n_d_dv;
    logic [32:0] w_dist;
    logic [32:0] w_sum33;

    logic        w_dv_v[0:DIV_STEPS];
    t_side       w_dv_side[0:DIV_STEPS];
    t_div        w_dv[0:DIV_STEPS];

    // stage e: shift amounts
    logic        r_e_v;
    t_side       r_e;
    logic [31:0] r_e_px;
    logic [31:0] r_e_py;
    logic [DIV_STEPS+30:0] w_pxf;
    logic [DIV_STEPS+30:0] w_pyf;

    t_out        w_res;
    logic signed [33:0] w_spx;
    logic signed [33:0] w_spy;

    logic        r_out_v;
    t_out        r_out;
    logic        r_skid_v;
    t_out        r_skid;
    logic        w_out_fire;

    assign w_en       = !r_skid_v;
    assign i_in.ready = w_en;
    assign w_out_fire = r_out_v && o_out.ready;
    assign o_out.valid = r_out_v;
    assign o_out.data  = r_out;

    always_comb begin
        w_dx  = 33'(i_in.data.second_x) - 33'(i_in.data.first_x);
        w_dy  = 33'(i_in.data.second_y) - 33'(i_in.data.first_y);
        w_adx = w_dx[32] ? 33'(-w_dx) : w_dx;
        w_ady = w_dy[32] ? 33'(-w_dy) : w_dy;
        w_sum = {1'b0, i_in.data.first_radius} + {1'b0, i_in.data.second_radius};
        n_a.hit   = i_in.data.first_is_circle && i_in.data.second_is_circle
                    && (w_adx <= {1'b0, w_sum}) && (w_ady <= {1'b0, w_sum});
        n_a.x1    = i_in.data.first_x;
        n_a.y1    = i_in.data.first_y;
        n_a.x2    = i_in.data.second_x;
        n_a.y2    = i_in.data.second_y;
        n_a.neg_x = w_dx[32];
        n_a.neg_y = w_dy[32];
        n_a.sum   = w_sum;
        n_a.adx   = w_adx[31:0];
        n_a.ady   = w_ady[31:0];
    end

    always_comb begin
        n_c     = r_b;
        n_c.hit = r_b.hit && (r_b_a < r_b_m2) && (r_b_b < (r_b_m2 - r_b_a));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_in.valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= w_sq_v[SQRT_STEPS];
            r_e_v <= w_dv_v[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a      <= n_a;
            r_b      <= r_a;
            r_b_a    <= r_a.adx * r_a.adx;
            r_b_b    <= r_a.ady * r_a.ady;
            r_b_m2   <= r_a.sum * r_a.sum;
            r_c      <= n_c;
            r_c_sq   <= {r_b_a + r_b_b, 64'd0};
            r_d      <= w_sq_side[SQRT_STEPS];
            r_d_dv   <= n_d_dv;
            r_e      <= w_dv_side[DIV_STEPS];
            r_e_px   <= w_dv_side[DIV_STEPS].hit ? {1'b0, w_pxf[FRAC_BITS +: 31]} : '0;
            r_e_py   <= w_dv_side[DIV_STEPS].hit ? {1'b0, w_pyf[FRAC_BITS +: 31]} : '0;
        end
    end

    assign w_sq_v[0]    = r_c_v;
    assign w_sq_side[0] = r_c;
    assign w_sq[0]      = r_c_sq;

    genvar g;
    generate
        for (g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
            col_sqrt_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (w_en),
                .i_idx  (5'(SQRT_STEPS - 1 - g)),
                .i_v    (w_sq_v[g]),
                .i_side (w_sq_side[g]),
                .i_sq   (w_sq[g]),
                .o_v    (w_sq_v[g+1]),
                .o_side (w_sq_side[g+1]),
                .o_sq   (w_sq[g+1])
            );
        end
    endgenerate

    // round to nearest, zero distance takes epsilon
    always_comb begin
        w_dist = w_sq[SQRT_STEPS].r[32:0]
                 + 33'(w_sq[SQRT_STEPS].n > w_sq[SQRT_STEPS].r);
        if (w_dist == '0) begin
            w_dist = EPS_RAW;
        end
        w_sum33       = {1'b0, w_sq_side[SQRT_STEPS].sum};
        n_d_dv.dvsr   = w_dist;
        n_d_dv.rem_x  = {2'b0, w_sq_side[SQRT_STEPS].adx[31:1]};
        n_d_dv.rem_y  = {2'b0, w_sq_side[SQRT_STEPS].ady[31:1]};
        n_d_dv.bit_x  = w_sq_side[SQRT_STEPS].adx[0];
        n_d_dv.bit_y  = w_sq_side[SQRT_STEPS].ady[0];
        n_d_dv.q_x    = '0;
        n_d_dv.q_y    = '0;
        n_d_dv.push   = (w_sum33 > w_dist) ? 31'((w_sum33 - w_dist) >> 1) : '0;
    end

    assign w_dv_v[0]    = r_d_v;
    assign w_dv_side[0] = r_d;
    assign w_dv[0]      = r_d_dv;

    generate
        for (g = 0; g < DIV_STEPS; g++) begin : g_div
            col_div_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (w_en),
                .i_v    (w_dv_v[g]),
                .i_side (w_dv_side[g]),
                .i_dv   (w_dv[g]),
                .o_v    (w_dv_v[g+1]),
                .o_side (w_dv_side[g+1]),
                .o_dv   (w_dv[g+1])
            );
        end
    endgenerate

    assign w_pxf = w_dv[DIV_STEPS].q_x * w_dv[DIV_STEPS].push;
    assign w_pyf = w_dv[DIV_STEPS].q_y * w_dv[DIV_STEPS].push;

    always_comb begin
        w_spx = r_e.neg_x ? -$signed({2'b0, r_e_px}) : $signed({2'b0, r_e_px});
        w_spy = r_e.neg_y ? -$signed({2'b0, r_e_py}) : $signed({2'b0, r_e_py});
        w_res.moved        = r_e.hit;
        w_res.new_first_x  = sat34($signed({{2{r_e.x1[31]}}, r_e.x1}) - w_spx);
        w_res.new_first_y  = sat34($signed({{2{r_e.y1[31]}}, r_e.y1}) - w_spy);
        w_res.new_second_x = sat34($signed({{2{r_e.x2[31]}}, r_e.x2}) + w_spx);
        w_res.new_second_y = sat34($signed({{2{r_e.y2[31]}}, r_e.y2}) + w_spy);
    end

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_out_fire) begin
                r_skid_v <= 1'b0;
            end
        end else if (r_e_v) begin
            if (!r_out_v || w_out_fire) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (w_out_fire) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_out_fire) begin
                r_out <= r_skid;
            end
        end else if (r_e_v) begin
            if (!r_out_v || w_out_fire) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a beat while output register is empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !o_out.ready))
        else $error("skid filled without a stalled output");

    a_no_shift_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_v && !r_e.hit) |-> (r_e_px == '0 && r_e_py == '0))
        else $error("shift on a pair that does not overlap");

endmodule

@@ sv/col_sqrt_cell.sv @@
// one digit cell of the pipelined square root chain
module col_sqrt_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [4:0]    i_idx,
    input  logic          i_v,
    input  col_pkg::t_side i_side,
    input  col_pkg::t_sqrt i_sq,
    output logic          o_v,
    output col_pkg::t_side o_side,
    output col_pkg::t_sqrt o_sq
);
    import col_pkg::*;

    logic [63:0] w_bit;
    logic [64:0] w_trial;
    t_sqrt       n_sq;

    always_comb begin
        w_bit   = 64'(1) << {i_idx, 1'b0};
        w_trial = {1'b0, i_sq.r} + {1'b0, w_bit};
        if ({1'b0, i_sq.n} >= w_trial) begin
            n_sq.n = i_sq.n - w_trial[63:0];
            n_sq.r = (i_sq.r >> 1) + w_bit;
        end else begin
            n_sq.n = i_sq.n;
            n_sq.r = i_sq.r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_v <= 1'b0;
        end else if (i_en) begin
            o_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side <= i_side;
            o_sq   <= n_sq;
        end
    end

endmodule

@@ sv/col_div_cell.sv @@
// one quotient bit for both normal components
module col_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_v,
    input  col_pkg::t_side i_side,
    input  col_pkg::t_div  i_dv,
    output logic          o_v,
    output col_pkg::t_side o_side,
    output col_pkg::t_div  o_dv
);
    import col_pkg::*;

    logic [33:0] w_tx;
    logic [33:0] w_ty;
    t_div        n_dv;

    always_comb begin
        n_dv       = i_dv;
        n_dv.bit_x = 1'b0;
        n_dv.bit_y = 1'b0;
        w_tx = {i_dv.rem_x, i_dv.bit_x};
        w_ty = {i_dv.rem_y, i_dv.bit_y};
        if (w_tx >= {1'b0, i_dv.dvsr}) begin
            n_dv.rem_x = 33'(w_tx - {1'b0, i_dv.dvsr});
            n_dv.q_x   = {i_dv.q_x[DIV_STEPS-2:0], 1'b1};
        end else begin
            n_dv.rem_x = w_tx[32:0];
            n_dv.q_x   = {i_dv.q_x[DIV_STEPS-2:0], 1'b0};
        end
        if (w_ty >= {1'b0, i_dv.dvsr}) begin
            n_dv.rem_y = 33'(w_ty - {1'b0, i_dv.dvsr});
            n_dv.q_y   = {i_dv.q_y[DIV_STEPS-2:0], 1'b1};
        end else begin
            n_dv.rem_y = w_ty[32:0];
            n_dv.q_y   = {i_dv.q_y[DIV_STEPS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_v <= 1'b0;
        end else if (i_en) begin
            o_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side <= i_side;
            o_dv   <= n_dv;
        end
    end

endmodule

@@ dv/tb_circle_overlap_resolver.sv @@
// self-checking testbench for the circle overlap resolver
`timescale 1ns / 100ps

module tb_circle_overlap_resolver;
    import col_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    col_in_if  pair_ch();
    col_out_if res_ch();

    circle_overlap_resolver uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (pair_ch.sink),
        .o_out  (res_ch.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_in  pending_pairs[$];
    t_out resolved_q[$];
    int   errors = 0;
    int   idle_run = 0;
    logic calm;
    int   sent_no = 0;
    int   hold_cycles = 0;
    int   beat_no = 0;

    // a stretch with no idling on either side
    assign calm = (sent_no >= 700) && (sent_no < 1000);

    function automatic longint unsigned root_round(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (n > r) r = r + 1;
        return r;
    endfunction

    function automatic longint shift_part(longint d, longint unsigned rdist,
                                          longint unsigned push);
        longint unsigned m, n, p;
        m = (d < 0) ? longint'(-d) : longint'(d);
        n = (m << FRAC_BITS) / rdist;
        p = (n * push) >> FRAC_BITS;
        return (d < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic t_out resolve_pair(t_in p);
        t_out o;
        longint x1, y1, x2, y2, dx, dy, px, py;
        longint unsigned sum, adx, ady, m2, a, b, rdist, push;
        x1 = p.first_x;  y1 = p.first_y;
        x2 = p.second_x; y2 = p.second_y;
        dx = x2 - x1; dy = y2 - y1;
        sum = longint'(p.first_radius) + longint'(p.second_radius);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        o.moved = 1'b0;
        px = 0; py = 0;
        if (p.first_is_circle && p.second_is_circle && adx <= sum && ady <= sum) begin
            m2 = sum * sum; a = adx * adx; b = ady * ady;
            if (a < m2 && b < m2 - a) begin
                rdist = root_round(a + b);
                if (rdist == 0) rdist = EPS_INT;
                push = (sum > rdist ? sum - rdist : 0) >> 1;
                px = shift_part(dx, rdist, push);
                py = shift_part(dy, rdist, push);
                o.moved = 1'b1;
            end
        end
        o.new_first_x  = clamp32(x1 - px);
        o.new_first_y  = clamp32(y1 - py);
        o.new_second_x = clamp32(x2 + px);
        o.new_second_y = clamp32(y2 + py);
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch beat %0d %s: got %h want %h", beat_no, what, got, want);
        errors++;
    endtask

    function automatic t_in near_pair(int spread, int rmax);
        t_in p;
        p.first_is_circle  = ($urandom_range(0, 15) != 0);
        p.second_is_circle = ($urandom_range(0, 15) != 0);
        p.first_x  = $urandom;
        p.first_y  = $urandom;
        p.second_x = p.first_x + $signed($urandom_range(0, 2 * spread)) - spread;
        p.second_y = p.first_y + $signed($urandom_range(0, 2 * spread)) - spread;
        p.first_radius  = 31'($urandom_range(0, rmax));
        p.second_radius = 31'($urandom_range(0, rmax));
        return p;
    endfunction

    function automatic t_in mk(logic c1, int x1, int y1, int r1,
                               logic c2, int x2, int y2, int r2);
        t_in p;
        p.first_is_circle = c1; p.first_x = x1; p.first_y = y1;
        p.first_radius = 31'(r1);
        p.second_is_circle = c2; p.second_x = x2; p.second_y = y2;
        p.second_radius = 31'(r2);
        return p;
    endfunction

    // driver: offers the next pending pair, idling at random, holding a waiting beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pair_ch.valid <= 1'b0;
        end else begin
            if (pair_ch.valid && pair_ch.ready) begin
                resolved_q.push_back(resolve_pair(pair_ch.data));
                void'(pending_pairs.pop_front());
                sent_no <= sent_no + 1;
            end
            if (!pair_ch.valid || pair_ch.ready) begin
                if (pending_pairs.size() > 0 &&
                    (calm || $urandom_range(0, 99) >= 19)) begin
                    pair_ch.valid <= 1'b1;
                    pair_ch.data  <= pending_pairs[0];
                end else begin
                    pair_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result beat against the oldest prediction
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (resolved_q.size() == 0) begin
                    report_mismatch("unexpected beat", '0, '0);
                end else begin
                    want = resolved_q.pop_front();
                    if (res_ch.data.moved !== want.moved)
                        report_mismatch("moved", {31'b0, res_ch.data.moved},
                                        {31'b0, want.moved});
                    if (res_ch.data.new_first_x !== want.new_first_x)
                        report_mismatch("new_first_x", res_ch.data.new_first_x, want.new_first_x);
                    if (res_ch.data.new_first_y !== want.new_first_y)
                        report_mismatch("new_first_y", res_ch.data.new_first_y, want.new_first_y);
                    if (res_ch.data.new_second_x !== want.new_second_x)
                        report_mismatch("new_second_x", res_ch.data.new_second_x,
                                        want.new_second_x);
                    if (res_ch.data.new_second_y !== want.new_second_y)
                        report_mismatch("new_second_y", res_ch.data.new_second_y,
                                        want.new_second_y);
                end
                beat_no++;
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= calm || ($urandom_range(0, 99) >= 19);
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((pair_ch.valid && pair_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run > 5000) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_in p;
        pair_ch.valid = 1'b0;
        pair_ch.data  = '0;
        res_ch.ready  = 1'b0;
        // directed: extremes, shape flags, box rejection, touching, coincident, saturation
        pending_pairs.push_back(mk(1, 0, 0, 65536, 1, 65536, 0, 65536));
        pending_pairs.push_back(mk(0, 0, 0, 65536, 1, 1000, 0, 65536));
        pending_pairs.push_back(mk(1, 0, 0, 65536, 0, 1000, 0, 65536));
        pending_pairs.push_back(mk(0, 5, 6, 7, 0, 8, 9, 10));
        pending_pairs.push_back(mk(1, 0, 0, 100, 1, 300, 0, 100));
        pending_pairs.push_back(mk(1, 0, 0, 100, 1, 0, 201, 100));
        pending_pairs.push_back(mk(1, 0, 0, 100, 1, 200, 0, 100));
        pending_pairs.push_back(mk(1, 0, 0, 100, 1, 150, 150, 100));
        pending_pairs.push_back(mk(1, 1234, -5678, 65536, 1, 1234, -5678, 65536));
        pending_pairs.push_back(mk(1, 0, 0, 0, 1, 0, 0, 0));
        pending_pairs.push_back(mk(1, 32'h7FFF_FFF0, 32'h7FFF_FFF0, 32'h7FFF_FFFF,
                                   1, 32'h7FFF_FFF0, 32'h7FFF_FF00, 32'h7FFF_FFFF));
        pending_pairs.push_back(mk(1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                   1, 32'h8000_0100, 32'h8000_0010, 32'h7FFF_FFFF));
        pending_pairs.push_back(mk(1, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF,
                                   1, 32'h8000_0000, 0, 32'h7FFF_FFFF));
        pending_pairs.push_back(mk(1, -1000, 2000, 3000, 1, 1000, -2000, 4000));
        pending_pairs.push_back(mk(1, 0, 0, 32'h7FFF_FFFF, 1, 1, 1, 32'h7FFF_FFFF));
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < 1700; i++) begin
            case ($urandom_range(0, 9))
                0: begin
                    p = near_pair(1, 1);
                    p.first_x = $urandom; p.second_x = $urandom;
                    p.first_y = $urandom; p.second_y = $urandom;
                    p.first_radius = 31'($urandom); p.second_radius = 31'($urandom);
                end
                1: p = near_pair(32'h4000_0000, 32'h7FFF_FFFF);
                2: p = near_pair(1 << 20, 1 << 20);
                3: p = near_pair(64, 64);
                default: p = near_pair(1 << 18, 1 << 18);
            endcase
            pending_pairs.push_back(p);
            if (i == 300) begin
                // receiver holds off while the sender keeps offering
                wait (pending_pairs.size() < 400);
                @(posedge i_clk);
                hold_cycles <= 300;
            end
        end
        wait (pending_pairs.size() == 0 && !pair_ch.valid);
        wait (resolved_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && resolved_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ circle_overlap_resolver.f @@
sv/col_pkg.sv
sv/col_in_if.sv
sv/col_out_if.sv
sv/col_sqrt_cell.sv
sv/col_div_cell.sv
sv/circle_overlap_resolver.sv
dv/tb_circle_overlap_resolver.sv
